### rtl/afpa_pkg.sv
package afpa_pkg;

  // Default datapath width (signed fixed point)
  localparam int DATA_WIDTH_DEF = 32;

  // Configuration register file
  localparam int TOL_W       = 31;
  localparam int COUNT_W     = 16;
  localparam int CFG_DATA_W  = 31;
  localparam int CFG_INDEX_W = 1;

  localparam logic [CFG_INDEX_W-1:0] REG_TOLERANCE = 1'b0;
  localparam logic [CFG_INDEX_W-1:0] REG_MAX_EVALS = 1'b1;

  localparam logic [TOL_W-1:0]   TOL_RESET       = 31'd66;
  localparam logic [COUNT_W-1:0] MAX_EVALS_RESET = 16'd100;

  // Evaluations per accelerated step and count ceiling
  localparam int                 STEP_EVALS = 3;
  localparam logic [COUNT_W-1:0] COUNT_MAX  = '1;

  // Item operation codes
  localparam logic OP_START = 1'b0;
  localparam logic OP_VALUE = 1'b1;

  // Result kind codes
  localparam logic KIND_REQUEST = 1'b0;
  localparam logic KIND_FINAL   = 1'b1;

  // Iteration phase
  typedef enum logic [2:0] {
    PH_IDLE,
    PH_WAIT_START,
    PH_WAIT_SECOND,
    PH_WAIT_THIRD,
    PH_WAIT_EXTRAP
  } phase_t;

  // Extrapolation sequencer state
  typedef enum logic [2:0] {
    EX_IDLE,
    EX_DIFF,
    EX_ABS,
    EX_MUL,
    EX_DIV,
    EX_FIN
  } ext_state_t;

  // Extrapolator status toward the iteration control
  typedef struct packed {
    logic busy;
    logic done;
  } ext_status_t;

endpackage

### rtl/afpa_item_if.sv
interface afpa_item_if #(
  parameter int DATA_WIDTH = afpa_pkg::DATA_WIDTH_DEF
);
  logic                         valid;
  logic                         ready;
  logic                         operation;
  logic signed [DATA_WIDTH-1:0] value;

  modport source (output valid, operation, value, input ready);
  modport sink (input valid, operation, value, output ready);
endinterface

### rtl/afpa_result_if.sv
interface afpa_result_if #(
  parameter int DATA_WIDTH = afpa_pkg::DATA_WIDTH_DEF
);
  logic                               valid;
  logic                               ready;
  logic                               kind;
  logic signed [DATA_WIDTH-1:0]       result_value;
  logic [afpa_pkg::COUNT_W-1:0]       evaluations;
  logic                               not_converged;

  modport source (output valid, kind, result_value, evaluations, not_converged, input ready);
  modport sink (input valid, kind, result_value, evaluations, not_converged, output ready);
endinterface

### rtl/afpa_mul.sv
// Bit-serial shift-add multiplier, one multiplier bit per cycle
module afpa_mul #(
  parameter int DATA_WIDTH = afpa_pkg::DATA_WIDTH_DEF
) (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      start,
  input  logic [DATA_WIDTH-1:0]     a,
  input  logic [DATA_WIDTH-1:0]     b,
  output logic                      done,
  output logic [2*DATA_WIDTH-1:0]   product
);

  localparam int              CNT_W = $clog2(DATA_WIDTH + 1);
  localparam logic [CNT_W-1:0] LAST = CNT_W'(DATA_WIDTH - 1);

  logic [DATA_WIDTH-1:0] mcand;
  logic [CNT_W-1:0]      cnt;
  logic                  busy;
  logic [DATA_WIDTH:0]   partial;

  // Add multiplicand into the upper half when the current multiplier bit is set
  assign partial = {1'b0, product[2*DATA_WIDTH-1:DATA_WIDTH]}
                 + {1'b0, (product[0] ? mcand : {DATA_WIDTH{1'b0}})};

  // Datapath: low half holds the remaining multiplier bits
  always_ff @(posedge clk) begin
    if (start) begin
      mcand   <= a;
      product <= {{DATA_WIDTH{1'b0}}, b};
    end else if (busy) begin
      product <= {partial, product[DATA_WIDTH-1:1]};
    end
  end

  // Bit counter
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= '0;
      end else if (busy) begin
        cnt <= cnt + CNT_W'(1);
        if (cnt == LAST) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

endmodule

### rtl/afpa_div.sv
// Bit-serial restoring divider, one quotient bit per cycle.
// Quotient is DATA_WIDTH+1 bits; big flags a quotient that does not fit.
module afpa_div #(
  parameter int DATA_WIDTH = afpa_pkg::DATA_WIDTH_DEF
) (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      start,
  input  logic [2*DATA_WIDTH-1:0]   num,
  input  logic [DATA_WIDTH:0]       den,
  output logic                      done,
  output logic [DATA_WIDTH:0]       quotient,
  output logic                      big
);

  localparam int               DW    = DATA_WIDTH + 1;
  localparam int               CNT_W = $clog2(DW + 1);
  localparam logic [CNT_W-1:0] LAST  = CNT_W'(DW - 1);

  logic [DW-1:0]    rem;
  logic [DW-1:0]    shreg;
  logic [CNT_W-1:0] cnt;
  logic             busy;
  logic [DW:0]      trial;
  logic [DW:0]      trial_sub;
  logic             fits;
  logic [DW-1:0]    num_top;

  // Dividend bits above the quotient field
  assign num_top   = {2'b00, num[2*DATA_WIDTH-1:DW]};
  assign trial     = {rem, shreg[DW-1]};
  assign trial_sub = trial - {1'b0, den};
  assign fits      = (trial >= {1'b0, den});
  assign quotient  = shreg;

  // Datapath: dividend bits shift out the top, quotient bits shift in
  always_ff @(posedge clk) begin
    if (start) begin
      rem   <= num_top;
      big   <= (num_top >= den);
      shreg <= num[DW-1:0];
    end else if (busy) begin
      rem   <= fits ? trial_sub[DW-1:0] : trial[DW-1:0];
      shreg <= {shreg[DW-2:0], fits};
    end
  end

  // Step counter
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= '0;
      end else if (busy) begin
        cnt <= cnt + CNT_W'(1);
        if (cnt == LAST) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

endmodule

### rtl/afpa_extrap.sv
// Delta-squared extrapolation: point = v3 + d2*d2/(d1-d2), saturated.
// Zero denominator gives v3.
module afpa_extrap #(
  parameter int DATA_WIDTH = afpa_pkg::DATA_WIDTH_DEF
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         start,
  input  logic [DATA_WIDTH-1:0]        v1,
  input  logic [DATA_WIDTH-1:0]        v2,
  input  logic [DATA_WIDTH-1:0]        v3,
  output afpa_pkg::ext_status_t        status,
  output logic [DATA_WIDTH-1:0]        point
);

  localparam int W = DATA_WIDTH;
  localparam logic [W-1:0] SAT_MAX = {1'b0, {(W-1){1'b1}}};
  localparam logic [W-1:0] SAT_MIN = {1'b1, {(W-1){1'b0}}};

  afpa_pkg::ext_state_t state, state_next;

  logic [W:0]     d1;
  logic [W:0]     d2;
  logic [W-1:0]   v3_q;
  logic [W+1:0]   den;
  logic [W-1:0]   mag_d2;
  logic [W:0]     mag_den;
  logic           den_neg;

  logic [W:0]     abs_d2;
  logic [W+1:0]   abs_den;
  logic           den_zero;

  logic           mul_start;
  logic           mul_done;
  logic [2*W-1:0] product;
  logic           div_start;
  logic           div_done;
  logic [W:0]     quo;
  logic           quo_big;

  logic [W+2:0]   v3_ext;
  logic [W+2:0]   quo_ext;
  logic [W+2:0]   sum;
  logic           sum_ovf;
  logic [W-1:0]   sat_point;

  assign abs_d2   = d2[W] ? (~d2 + 1'b1) : d2;
  assign abs_den  = den[W+1] ? (~den + 1'b1) : den;
  assign den_zero = (den == '0);

  // Final add and saturation to the signed data range; quotient can reach
  // nearly four times the data range, so the sum keeps three guard bits
  assign v3_ext  = {{3{v3_q[W-1]}}, v3_q};
  assign quo_ext = {2'b00, quo};
  assign sum     = den_neg ? (v3_ext - quo_ext) : (v3_ext + quo_ext);
  assign sum_ovf = !((sum[W+2:W-1] == 4'b0000) || (sum[W+2:W-1] == 4'b1111));

  always_comb begin
    if (quo_big) begin
      sat_point = den_neg ? SAT_MIN : SAT_MAX;
    end else if (sum_ovf) begin
      sat_point = sum[W+2] ? SAT_MIN : SAT_MAX;
    end else begin
      sat_point = sum[W-1:0];
    end
  end

  afpa_mul #(.DATA_WIDTH(DATA_WIDTH)) u_mul (
    .clk     (clk),
    .rst     (rst),
    .start   (mul_start),
    .a       (mag_d2),
    .b       (mag_d2),
    .done    (mul_done),
    .product (product)
  );

  afpa_div #(.DATA_WIDTH(DATA_WIDTH)) u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .num      (product),
    .den      (mag_den),
    .done     (div_done),
    .quotient (quo),
    .big      (quo_big)
  );

  // Datapath registers, loaded on start and in the DIFF, ABS and DIV sequencer states
  always_ff @(posedge clk) begin
    if (start) begin
      d1   <= {v2[W-1], v2} - {v1[W-1], v1};
      d2   <= {v3[W-1], v3} - {v2[W-1], v2};
      v3_q <= v3;
    end
    if (state == afpa_pkg::EX_DIFF) begin
      den    <= {d1[W], d1} - {d2[W], d2};
      mag_d2 <= abs_d2[W-1:0];
    end
    if (state == afpa_pkg::EX_ABS) begin
      mag_den <= abs_den[W:0];
      den_neg <= den[W+1];
      if (den_zero) begin
        point <= v3_q;
      end
    end
    if ((state == afpa_pkg::EX_DIV) && div_done) begin
      point <= sat_point;
    end
  end

  // Sequencer state register
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= afpa_pkg::EX_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Next state and unit handshakes
  always_comb begin
    state_next  = state;
    mul_start   = 1'b0;
    div_start   = 1'b0;
    status.busy = (state != afpa_pkg::EX_IDLE);
    status.done = (state == afpa_pkg::EX_FIN);
    unique case (state)
      afpa_pkg::EX_IDLE: begin
        if (start) begin
          state_next = afpa_pkg::EX_DIFF;
        end
      end
      afpa_pkg::EX_DIFF: begin
        state_next = afpa_pkg::EX_ABS;
      end
      afpa_pkg::EX_ABS: begin
        if (den_zero) begin
          state_next = afpa_pkg::EX_FIN;
        end else begin
          mul_start  = 1'b1;
          state_next = afpa_pkg::EX_MUL;
        end
      end
      afpa_pkg::EX_MUL: begin
        if (mul_done) begin
          div_start  = 1'b1;
          state_next = afpa_pkg::EX_DIV;
        end
      end
      afpa_pkg::EX_DIV: begin
        if (div_done) begin
          state_next = afpa_pkg::EX_FIN;
        end
      end
      afpa_pkg::EX_FIN: begin
        state_next = afpa_pkg::EX_IDLE;
      end
      default: begin
        state_next = afpa_pkg::EX_IDLE;
      end
    endcase
  end

  // A new extrapolation only starts when the sequencer is free
  a_start_idle: assert property (@(posedge clk) disable iff (rst)
    start |-> (state == afpa_pkg::EX_IDLE))
    else $error("extrapolation started while busy");

  // Divider is only launched with a nonzero denominator
  a_div_den: assert property (@(posedge clk) disable iff (rst)
    div_start |-> (mag_den != '0))
    else $error("division launched with zero denominator");

  // Multiplier finishes only while the sequencer waits on it
  a_mul_done: assert property (@(posedge clk) disable iff (rst)
    mul_done |-> (state == afpa_pkg::EX_MUL))
    else $error("unexpected multiplier completion");

endmodule

### rtl/aitken_fixed_point_accelerator.sv
// Channel   Dir  Payload                                            Role
// item      in   operation, value                                   start point or f(x)
// result    out  kind, result_value, evaluations, not_converged     request point or answer
// cfg_*     in   cfg_write, cfg_index, cfg_data                      tolerance, max_evaluations
//
// Most items reach the result register in the cycle after transfer.
// The third value of a step passes through a bit-serial multiplier followed by a
// bit-serial divider before the extrapolated point reaches the result register.
// With a zero denominator both units are skipped.
// rst is synchronous: phase goes idle, the registers take their reset values.
// One result register; item.ready is low while extrapolating or while a result is held
// and result.ready is low.
module aitken_fixed_point_accelerator #(
  parameter int DATA_WIDTH = afpa_pkg::DATA_WIDTH_DEF
) (
  input  logic                                clk,
  input  logic                                rst,
  afpa_item_if.sink                           item,
  afpa_result_if.source                       result,
  input  logic                                cfg_write,
  input  logic [afpa_pkg::CFG_INDEX_W-1:0]    cfg_index,
  input  logic [afpa_pkg::CFG_DATA_W-1:0]     cfg_data
);

  localparam int W     = DATA_WIDTH;
  localparam int CW    = afpa_pkg::COUNT_W;
  localparam int CMP_W = ((W + 1) > afpa_pkg::TOL_W) ? (W + 1) : afpa_pkg::TOL_W;

  afpa_pkg::phase_t phase, phase_next;

  logic [afpa_pkg::TOL_W-1:0] tolerance;
  logic [CW-1:0]              max_evals;
  logic [W-1:0]               cur_point, cur_point_next;
  logic [W-1:0]               first_value, first_value_next;
  logic [W-1:0]               second_value, second_value_next;
  logic [CW-1:0]              eval_count, eval_count_next;

  logic                       out_valid, out_valid_next;
  logic                       out_kind, out_kind_next;
  logic [W-1:0]               out_value, out_value_next;
  logic [CW-1:0]              out_evals, out_evals_next;
  logic                       out_nc, out_nc_next;

  logic                       accept;
  logic                       ext_start;
  afpa_pkg::ext_status_t      ext_status;
  logic [W-1:0]               ext_point;

  logic [W:0]                 diff;
  logic [W:0]                 adiff;
  logic [CW:0]                count_sum;
  logic [CW-1:0]              count_step;
  logic                       keep_going;

  assign accept     = item.valid && item.ready;
  assign item.ready = !ext_status.busy && (!out_valid || result.ready);

  assign result.valid         = out_valid;
  assign result.kind          = out_kind;
  assign result.result_value  = out_value;
  assign result.evaluations   = out_evals;
  assign result.not_converged = out_nc;

  // Convergence test on |f(x) - x| and the updated count
  assign diff      = {item.value[W-1], item.value} - {cur_point[W-1], cur_point};
  assign adiff     = diff[W] ? (~diff + 1'b1) : diff;
  assign count_sum = {1'b0, eval_count} + (CW + 1)'(afpa_pkg::STEP_EVALS);
  assign count_step = (phase == afpa_pkg::PH_WAIT_START) ? CW'(1) :
                      (count_sum[CW] ? afpa_pkg::COUNT_MAX : count_sum[CW-1:0]);
  assign keep_going = (CMP_W'(adiff) > CMP_W'(tolerance)) && (count_step < max_evals);

  afpa_extrap #(.DATA_WIDTH(DATA_WIDTH)) u_extrap (
    .clk    (clk),
    .rst    (rst),
    .start  (ext_start),
    .v1     (first_value),
    .v2     (second_value),
    .v3     (item.value),
    .status (ext_status),
    .point  (ext_point)
  );

  // Control registers and configuration
  always_ff @(posedge clk) begin
    if (rst) begin
      phase      <= afpa_pkg::PH_IDLE;
      out_valid  <= 1'b0;
      eval_count <= '0;
      tolerance  <= afpa_pkg::TOL_RESET;
      max_evals  <= afpa_pkg::MAX_EVALS_RESET;
    end else begin
      phase      <= phase_next;
      out_valid  <= out_valid_next;
      eval_count <= eval_count_next;
      if (cfg_write) begin
        unique case (cfg_index)
          afpa_pkg::REG_TOLERANCE: tolerance <= cfg_data[afpa_pkg::TOL_W-1:0];
          afpa_pkg::REG_MAX_EVALS: max_evals <= cfg_data[CW-1:0];
          default: ;
        endcase
      end
    end
  end

  // Iteration values and result payload
  always_ff @(posedge clk) begin
    cur_point    <= cur_point_next;
    first_value  <= first_value_next;
    second_value <= second_value_next;
    out_kind     <= out_kind_next;
    out_value    <= out_value_next;
    out_evals    <= out_evals_next;
    out_nc       <= out_nc_next;
  end

  // Phase sequencing and result formation
  always_comb begin
    phase_next        = phase;
    cur_point_next    = cur_point;
    first_value_next  = first_value;
    second_value_next = second_value;
    eval_count_next   = eval_count;
    out_valid_next    = out_valid && !result.ready;
    out_kind_next     = out_kind;
    out_value_next    = out_value;
    out_evals_next    = out_evals;
    out_nc_next       = out_nc;
    ext_start         = 1'b0;

    if (accept) begin
      if (item.operation == afpa_pkg::OP_START) begin
        // Start (also restarts a running iteration)
        cur_point_next  = item.value;
        eval_count_next = '0;
        phase_next      = afpa_pkg::PH_WAIT_START;
        out_valid_next  = 1'b1;
        out_kind_next   = afpa_pkg::KIND_REQUEST;
        out_value_next  = item.value;
        out_evals_next  = '0;
        out_nc_next     = 1'b0;
      end else begin
        unique case (phase)
          afpa_pkg::PH_WAIT_START, afpa_pkg::PH_WAIT_EXTRAP: begin
            eval_count_next = count_step;
            out_valid_next  = 1'b1;
            out_value_next  = item.value;
            out_evals_next  = count_step;
            if (keep_going) begin
              first_value_next = item.value;
              phase_next       = afpa_pkg::PH_WAIT_SECOND;
              out_kind_next    = afpa_pkg::KIND_REQUEST;
              out_nc_next      = 1'b0;
            end else begin
              phase_next    = afpa_pkg::PH_IDLE;
              out_kind_next = afpa_pkg::KIND_FINAL;
              out_nc_next   = (count_step >= max_evals);
            end
          end
          afpa_pkg::PH_WAIT_SECOND: begin
            second_value_next = item.value;
            phase_next        = afpa_pkg::PH_WAIT_THIRD;
            out_valid_next    = 1'b1;
            out_kind_next     = afpa_pkg::KIND_REQUEST;
            out_value_next    = item.value;
            out_evals_next    = eval_count;
            out_nc_next       = 1'b0;
          end
          afpa_pkg::PH_WAIT_THIRD: begin
            ext_start = 1'b1;
          end
          default: begin
            // Function value with no iteration running: dropped
            phase_next = afpa_pkg::PH_IDLE;
          end
        endcase
      end
    end

    // Extrapolated point becomes the next request
    if (ext_status.done) begin
      cur_point_next = ext_point;
      phase_next     = afpa_pkg::PH_WAIT_EXTRAP;
      out_valid_next = 1'b1;
      out_kind_next  = afpa_pkg::KIND_REQUEST;
      out_value_next = ext_point;
      out_evals_next = eval_count;
      out_nc_next    = 1'b0;
    end
  end

  // Result register is always free when the extrapolation completes
  a_slot_free: assert property (@(posedge clk) disable iff (rst)
    ext_status.done |-> !out_valid)
    else $error("extrapolated point with result register occupied");

  // Extrapolation only completes inside the third-value phase
  a_done_phase: assert property (@(posedge clk) disable iff (rst)
    ext_status.done |-> (phase == afpa_pkg::PH_WAIT_THIRD))
    else $error("extrapolation completed outside its phase");

  // A stray function value while idle produces nothing
  a_idle_silent: assert property (@(posedge clk) disable iff (rst)
    (accept && (item.operation == afpa_pkg::OP_VALUE) && (phase == afpa_pkg::PH_IDLE))
    |=> !out_valid)
    else $error("result produced for value while idle");

  // Unconverged answers only at or beyond the evaluation limit
  a_nc_limit: assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_nc) |-> ((out_kind == afpa_pkg::KIND_FINAL) && (out_evals >= max_evals)))
    else $error("not_converged flag without reaching the limit");

endmodule
